// ===== hdl/kth_smallest_two_sorted_arrays_unit_assert.svh =====
// assertion macros for the k-th smallest unit
`ifndef KTH_SMALLEST_TWO_SORTED_ARRAYS_UNIT_ASSERT_SVH
`define KTH_SMALLEST_TWO_SORTED_ARRAYS_UNIT_ASSERT_SVH

// condition holds at every edge out of reset
`define KTH_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define KTH_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define KTH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/kth_pkg.sv =====
// types and constants of the k-th smallest unit
`default_nettype none

package kth_pkg;

    localparam int STORE_DEPTH_DEF = 64;
    localparam int VALUE_W         = 32;
    localparam int RANK_W          = 8;

    typedef enum logic [1:0] {
        ACT_APPEND_FIRST  = 2'd0,
        ACT_APPEND_SECOND = 2'd1,
        ACT_QUERY         = 2'd2,
        ACT_CLEAR         = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_RANK_ERR = 2'd1,
        STATUS_FULL     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEL,
        ST_CMP,
        ST_FIN
    } state_t;

    typedef struct packed {
        action_t                    action;
        logic signed [VALUE_W-1:0]  value;
        logic        [RANK_W-1:0]   rank;
    } cmd_word_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  kth_value;
        status_t                    status;
    } res_word_t;

endpackage

`default_nettype wire

// ===== hdl/kth_smallest_two_sorted_arrays_unit.sv =====
// top level of the k-th smallest of two sorted stores unit
//
// usage: a command word enters on cmd (valid/ready). action 0 or 1 appends
// value to the first or second store, 2 asks for the rank-th smallest value
// of both stores merged, 3 empties both stores. a result word leaves on res
// (valid/ready) for each query and for each append to a full store.
// clears give no word, and appends give none unless the store is full.
// a query runs n halving steps, n being at most 2*log2(STORE_DEPTH) + 1 (13
// at the default depth): each step reads both middle elements from the two
// store memories in the SEL state and compares them in the CMP state; one
// more read fetches the selected element.
// a bad rank or an append to a full store gives its word in the cycle after
// the command is taken.
// one command is handled at a time: cmd_ready is low during a query and while
// a word is stalled on res, and a query that finishes while res is stalled
// holds its result until res drains.
// reset clears both counts and empties the output register; the store
// memories are not cleared, entries above the counts are never read.
`default_nettype none

module kth_smallest_two_sorted_arrays_unit #(
    parameter int STORE_DEPTH = kth_pkg::STORE_DEPTH_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cmd_valid,
    output logic                cmd_ready,
    input  kth_pkg::cmd_word_t  cmd,
    output logic                res_valid,
    input  wire                 res_ready,
    output kth_pkg::res_word_t  res
);

    `include "kth_smallest_two_sorted_arrays_unit_assert.svh"

    // address, count, rank-compare and final-index widths
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int SW = ((CW + 1) > kth_pkg::RANK_W) ? (CW + 1) : kth_pkg::RANK_W;
    localparam int FW = SW + 1;
    localparam int VW = kth_pkg::VALUE_W;
    localparam int RW = kth_pkg::RANK_W;
    localparam logic [CW-1:0] COUNT_MAX = CW'(STORE_DEPTH);
    localparam logic [FW-1:0] IDX_LIMIT = FW'(STORE_DEPTH);

    // store memories
    logic [VW-1:0] first_mem  [STORE_DEPTH];
    logic [VW-1:0] second_mem [STORE_DEPTH];

    kth_pkg::state_t state_reg, state_next;

    logic [CW-1:0] first_count_reg, first_count_next;
    logic [CW-1:0] second_count_reg, second_count_next;

    // search windows and remaining rank
    logic [CW-1:0] a_lo_reg, a_lo_next, a_hi_reg, a_hi_next;
    logic [CW-1:0] b_lo_reg, b_lo_next, b_hi_reg, b_hi_next;
    logic [CW-1:0] ha_reg, ha_next, hb_reg, hb_next;
    logic [RW-1:0] k_reg, k_next;
    logic          fin_sel_reg, fin_sel_next;   // 1: answer comes from second store
    logic          fin_oob_reg, fin_oob_next;

    logic                res_valid_reg, res_valid_next;
    kth_pkg::res_word_t  res_reg, res_next;

    // memory ports
    logic          wr_a, wr_b;
    logic          rd_en_a, rd_en_b;
    logic [AW-1:0] rd_addr_a, rd_addr_b;
    logic [VW-1:0] rd_data_a, rd_data_b;

    // helpers
    logic [CW:0]   total_count;
    logic          rank_err;
    logic [CW-1:0] ha_calc, hb_calc;
    logic [FW-1:0] fin_idx;
    logic [SW-1:0] split_sum;
    logic          a_ge;

    // conditions watched by the checks below
    logic          counts_in_range;
    logic          windows_live;
    logic          windows_in_count;
    logic          in_cmp;
    logic          busy;
    logic          search_on;
    logic          query_go;

    assign total_count = {1'b0, first_count_reg} + {1'b0, second_count_reg};
    assign rank_err    = (cmd.rank == '0) || (SW'(cmd.rank) > SW'(total_count));

    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            first_mem[first_count_reg[AW-1:0]] <= cmd.value;
        end
        if (rd_en_a)
        begin
            rd_data_a <= first_mem[rd_addr_a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_b)
        begin
            second_mem[second_count_reg[AW-1:0]] <= cmd.value;
        end
        if (rd_en_b)
        begin
            rd_data_b <= second_mem[rd_addr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= kth_pkg::ST_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            res_valid_reg    <= res_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        a_lo_reg    <= a_lo_next;
        a_hi_reg    <= a_hi_next;
        b_lo_reg    <= b_lo_next;
        b_hi_reg    <= b_hi_next;
        ha_reg      <= ha_next;
        hb_reg      <= hb_next;
        k_reg       <= k_next;
        fin_sel_reg <= fin_sel_next;
        fin_oob_reg <= fin_oob_next;
        res_reg     <= res_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        a_lo_next         = a_lo_reg;
        a_hi_next         = a_hi_reg;
        b_lo_next         = b_lo_reg;
        b_hi_next         = b_hi_reg;
        ha_next           = ha_reg;
        hb_next           = hb_reg;
        k_next            = k_reg;
        fin_sel_next      = fin_sel_reg;
        fin_oob_next      = fin_oob_reg;
        res_valid_next    = res_valid_reg;
        res_next          = res_reg;
        cmd_ready         = 1'b0;
        wr_a              = 1'b0;
        wr_b              = 1'b0;
        rd_en_a           = 1'b0;
        rd_en_b           = 1'b0;
        rd_addr_a         = '0;
        rd_addr_b         = '0;
        ha_calc           = (a_hi_reg - a_lo_reg) >> 1;
        hb_calc           = (b_hi_reg - b_lo_reg) >> 1;
        fin_idx           = '0;
        split_sum         = SW'(ha_reg) + SW'(hb_reg) + SW'(1);
        a_ge              = $signed(rd_data_a) >= $signed(rd_data_b);

        // output word drains
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            kth_pkg::ST_IDLE:
            begin
                cmd_ready = !res_valid_reg || res_ready;
                if (cmd_valid && cmd_ready)
                begin
                    unique case (cmd.action)
                        kth_pkg::ACT_APPEND_FIRST:
                        begin
                            if (first_count_reg == COUNT_MAX)
                            begin
                                res_valid_next     = 1'b1;
                                res_next.kth_value = '0;
                                res_next.status    = kth_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_a             = 1'b1;
                                first_count_next = first_count_reg + CW'(1);
                            end
                        end
                        kth_pkg::ACT_APPEND_SECOND:
                        begin
                            if (second_count_reg == COUNT_MAX)
                            begin
                                res_valid_next     = 1'b1;
                                res_next.kth_value = '0;
                                res_next.status    = kth_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                wr_b              = 1'b1;
                                second_count_next = second_count_reg + CW'(1);
                            end
                        end
                        kth_pkg::ACT_QUERY:
                        begin
                            if (rank_err)
                            begin
                                res_valid_next     = 1'b1;
                                res_next.kth_value = '0;
                                res_next.status    = kth_pkg::STATUS_RANK_ERR;
                            end
                            else
                            begin
                                a_lo_next  = '0;
                                a_hi_next  = first_count_reg;
                                b_lo_next  = '0;
                                b_hi_next  = second_count_reg;
                                k_next     = cmd.rank;
                                state_next = kth_pkg::ST_SEL;
                            end
                        end
                        kth_pkg::ACT_CLEAR:
                        begin
                            first_count_next  = '0;
                            second_count_next = '0;
                        end
                    endcase
                end
            end

            kth_pkg::ST_SEL:
            begin
                if (b_lo_reg >= b_hi_reg)
                begin
                    // second window empty: index into the first
                    fin_idx      = FW'(a_lo_reg) + FW'(k_reg) - FW'(1);
                    fin_sel_next = 1'b0;
                    fin_oob_next = fin_idx >= IDX_LIMIT;
                    rd_en_a      = 1'b1;
                    rd_addr_a    = fin_idx[AW-1:0];
                    state_next   = kth_pkg::ST_FIN;
                end
                else if (a_lo_reg >= a_hi_reg)
                begin
                    fin_idx      = FW'(b_lo_reg) + FW'(k_reg) - FW'(1);
                    fin_sel_next = 1'b1;
                    fin_oob_next = fin_idx >= IDX_LIMIT;
                    rd_en_b      = 1'b1;
                    rd_addr_b    = fin_idx[AW-1:0];
                    state_next   = kth_pkg::ST_FIN;
                end
                else
                begin
                    // fetch both middle elements
                    ha_next    = ha_calc;
                    hb_next    = hb_calc;
                    rd_en_a    = 1'b1;
                    rd_en_b    = 1'b1;
                    rd_addr_a  = AW'(a_lo_reg + ha_calc);
                    rd_addr_b  = AW'(b_lo_reg + hb_calc);
                    state_next = kth_pkg::ST_CMP;
                end
            end

            kth_pkg::ST_CMP:
            begin
                if (a_ge)
                begin
                    if (SW'(k_reg) <= split_sum)
                    begin
                        a_hi_next = a_lo_reg + ha_reg;
                    end
                    else
                    begin
                        b_lo_next = b_lo_reg + hb_reg + CW'(1);
                        k_next    = k_reg - RW'(SW'(hb_reg) + SW'(1));
                    end
                end
                else
                begin
                    if (SW'(k_reg) <= split_sum)
                    begin
                        b_hi_next = b_lo_reg + hb_reg;
                    end
                    else
                    begin
                        a_lo_next = a_lo_reg + ha_reg + CW'(1);
                        k_next    = k_reg - RW'(SW'(ha_reg) + SW'(1));
                    end
                end
                state_next = kth_pkg::ST_SEL;
            end

            kth_pkg::ST_FIN:
            begin
                // wait for a free output register
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next = 1'b1;
                    res_next.status = kth_pkg::STATUS_OK;
                    if (fin_oob_reg)
                    begin
                        res_next.kth_value = '0;
                    end
                    else if (fin_sel_reg)
                    begin
                        res_next.kth_value = rd_data_b;
                    end
                    else
                    begin
                        res_next.kth_value = rd_data_a;
                    end
                    state_next = kth_pkg::ST_IDLE;
                end
            end
        endcase
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign counts_in_range  = (first_count_reg <= COUNT_MAX) && (second_count_reg <= COUNT_MAX);
    assign windows_live     = (a_lo_reg < a_hi_reg) && (b_lo_reg < b_hi_reg);
    assign windows_in_count = (a_hi_reg <= first_count_reg) && (b_hi_reg <= second_count_reg);
    assign in_cmp           = state_reg == kth_pkg::ST_CMP;
    assign busy             = state_reg != kth_pkg::ST_IDLE;
    assign search_on        = (state_reg == kth_pkg::ST_SEL) || (state_reg == kth_pkg::ST_CMP);
    assign query_go         = cmd_valid && cmd_ready && (cmd.action == kth_pkg::ACT_QUERY)
                              && !rank_err;

    // counts never pass the store depth
    `KTH_ASSERT_HOLDS(a_count_bound, counts_in_range, "store count above depth")
    // a compare step only runs on two non-empty windows
    `KTH_ASSERT_IMPLIES(a_cmp_windows, in_cmp, windows_live, "compare on empty window")
    // windows stay inside the filled part of each store
    `KTH_ASSERT_IMPLIES(a_window_bound, busy, windows_in_count, "window beyond count")
    // remaining rank never reaches zero during a search
    `KTH_ASSERT_IMPLIES(a_rank_live, search_on, k_reg != '0, "rank exhausted during search")
    // a good query starts the search in the next cycle
    `KTH_ASSERT_NEXT(a_query_starts, query_go, state_reg == kth_pkg::ST_SEL, "query did not start")

endmodule

`default_nettype wire

// ===== tb/sv/tb_kth_smallest_two_sorted_arrays_unit.sv =====
// testbench for the k-th smallest of two sorted stores unit, checked against a predictor
`timescale 1ns / 1ps

module tb_kth_smallest_two_sorted_arrays_unit;

    localparam int DEPTH         = kth_pkg::STORE_DEPTH_DEF;
    localparam int ITEM_TARGET   = 1550;
    localparam int SETTLE_CYCLES = 40;
    localparam int PRINT_CAP     = 100;

    // one line of the directed table: a command word and, where it is plain,
    // the result word it must give
    typedef struct {
        kth_pkg::cmd_word_t w;
        bit                 typed;
        kth_pkg::res_word_t r;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cmd_valid;
    logic               cmd_ready;
    kth_pkg::cmd_word_t cmd;
    logic               res_valid;
    logic               res_ready;
    kth_pkg::res_word_t res;

    // predictor copy of both stores
    logic [31:0] first_mem  [DEPTH];
    logic [31:0] second_mem [DEPTH];
    int unsigned first_cnt;
    int unsigned second_cnt;

    // result words still owed by the unit, oldest first
    kth_pkg::res_word_t pending_results[$];

    // fill levels as the stimulus side sees them, used to pick ranks
    int unsigned seen_first;
    int unsigned seen_second;

    // typed expectation travelling with the word on the command channel
    bit                 typed_row;
    kth_pkg::res_word_t typed_res;

    bit src_idle_on;
    bit sink_idle_on;
    int sink_hold;

    int items_sent;
    int mismatch_count;
    int words_checked;
    int n_queries;
    int n_ok;
    int n_rank_err;
    int n_full;
    int n_clears;
    int max_first;
    int max_second;

    dir_row_t dir_tab[$];

    kth_smallest_two_sorted_arrays_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog, several times the slowest legal run
    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

    // store read that gives zero past the end, as the halving loop expects
    function automatic logic [31:0] first_at(int unsigned i);
        return (i < DEPTH) ? first_mem[i] : 32'd0;
    endfunction

    function automatic logic [31:0] second_at(int unsigned i);
        return (i < DEPTH) ? second_mem[i] : 32'd0;
    endfunction

    // k-th smallest of both stores by window halving
    function automatic logic [31:0] kth_of_stores(int unsigned k);
        int unsigned a_lo;
        int unsigned a_hi;
        int unsigned b_lo;
        int unsigned b_hi;
        int unsigned ha;
        int unsigned hb;
        bit          a_ge;
        a_lo = 0;
        a_hi = first_cnt;
        b_lo = 0;
        b_hi = second_cnt;
        while (1)
        begin
            // one window empty: index straight into the other
            if (b_lo >= b_hi)
                return first_at(a_lo + k - 1);
            if (a_lo >= a_hi)
                return second_at(b_lo + k - 1);
            ha   = (a_hi - a_lo) / 2;
            hb   = (b_hi - b_lo) / 2;
            a_ge = ($signed(first_at(a_lo + ha)) >= $signed(second_at(b_lo + hb)));
            if (k <= ha + hb + 1)
            begin
                // k lies below the larger middle: drop that window's tail
                if (a_ge)
                    a_hi = a_lo + ha;
                else
                    b_hi = b_lo + hb;
            end
            else
            begin
                // k lies above the smaller middle: drop that window's head
                if (a_ge)
                begin
                    b_lo = b_lo + hb + 1;
                    k    = k - (hb + 1);
                end
                else
                begin
                    a_lo = a_lo + ha + 1;
                    k    = k - (ha + 1);
                end
            end
        end
    endfunction

    // apply one accepted command word to the predictor stores
    task automatic apply_to_stores(input kth_pkg::cmd_word_t w, output bit gives,
                                   output kth_pkg::res_word_t r);
        gives       = 1'b0;
        r.kth_value = '0;
        r.status    = kth_pkg::STATUS_OK;
        case (w.action)
            kth_pkg::ACT_APPEND_FIRST:
            begin
                if (first_cnt >= DEPTH)
                begin
                    gives    = 1'b1;
                    r.status = kth_pkg::STATUS_FULL;
                end
                else
                begin
                    first_mem[first_cnt] = w.value;
                    first_cnt++;
                end
            end
            kth_pkg::ACT_APPEND_SECOND:
            begin
                if (second_cnt >= DEPTH)
                begin
                    gives    = 1'b1;
                    r.status = kth_pkg::STATUS_FULL;
                end
                else
                begin
                    second_mem[second_cnt] = w.value;
                    second_cnt++;
                end
            end
            kth_pkg::ACT_QUERY:
            begin
                gives = 1'b1;
                if (w.rank == 0 || w.rank > first_cnt + second_cnt)
                    r.status = kth_pkg::STATUS_RANK_ERR;
                else
                    r.kth_value = kth_of_stores({24'd0, w.rank});
            end
            default:
            begin
                first_cnt  = 0;
                second_cnt = 0;
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        // keep the log short when the unit is badly off
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] mismatch on result word %0d: %s", $time, words_checked, msg);
    endtask

    // mostly back to back, now and then a long pause
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // predict on every accepted command word, check every accepted result word
    always @(posedge clk)
    begin : watch_words
        bit                 gives;
        kth_pkg::res_word_t pred;
        kth_pkg::res_word_t exp_w;
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
            begin
                apply_to_stores(cmd, gives, pred);
                if (gives)
                    pending_results.push_back(typed_row ? typed_res : pred);
                if (cmd.action == kth_pkg::ACT_QUERY)
                    n_queries++;
                if (cmd.action == kth_pkg::ACT_CLEAR)
                    n_clears++;
                if (gives && pred.status == kth_pkg::STATUS_OK)
                    n_ok++;
                if (gives && pred.status == kth_pkg::STATUS_RANK_ERR)
                    n_rank_err++;
                if (gives && pred.status == kth_pkg::STATUS_FULL)
                    n_full++;
                if (first_cnt > max_first)
                    max_first = first_cnt;
                if (second_cnt > max_second)
                    max_second = second_cnt;
            end
            if (res_valid && res_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result word with nothing pending");
                else
                begin
                    exp_w = pending_results.pop_front();
                    if (res.kth_value !== exp_w.kth_value)
                        report_mismatch($sformatf("kth_value %0d, want %0d",
                                                  res.kth_value, exp_w.kth_value));
                    if (res.status !== exp_w.status)
                        report_mismatch($sformatf("status %0d, want %s",
                                                  res.status, exp_w.status.name()));
                end
                words_checked++;
            end
        end
    end

    // receiving side: random stalls of mixed length, off in some stretches
    always @(negedge clk)
    begin
        if (!rst_n)
            res_ready <= 1'b0;
        else if (sink_hold > 0)
        begin
            sink_hold = sink_hold - 1;
            res_ready <= 1'b0;
        end
        else if (sink_idle_on && $urandom_range(0, 3) == 0)
        begin
            sink_hold = gap_len();
            res_ready <= 1'b0;
        end
        else
            res_ready <= 1'b1;
    end

    // drive one command word at a falling edge and hold it until it is taken
    task automatic send_word(input kth_pkg::cmd_word_t w, input bit typed,
                             input kth_pkg::res_word_t tres);
        int gap;
        gap = src_idle_on ? gap_len() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd       <= w;
        cmd_valid <= 1'b1;
        typed_row = typed;
        typed_res = tres;
        do
            @(posedge clk);
        while (!(cmd_valid && cmd_ready));
        items_sent++;
        case (w.action)
            kth_pkg::ACT_APPEND_FIRST:  if (seen_first < DEPTH) seen_first++;
            kth_pkg::ACT_APPEND_SECOND: if (seen_second < DEPTH) seen_second++;
            kth_pkg::ACT_CLEAR:
            begin
                seen_first  = 0;
                seen_second = 0;
            end
            default: ;
        endcase
    endtask

    // hold off the sender until every owed word is back, then let the unit settle
    task automatic wait_for_results();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic dir_row_t mk(kth_pkg::action_t a, logic [31:0] v, int k,
                                    int typed, logic [31:0] kv, kth_pkg::status_t st);
        dir_row_t row;
        row.w.action    = a;
        row.w.value     = v;
        row.w.rank      = 8'(k);
        row.typed       = (typed != 0);
        row.r.kth_value = kv;
        row.r.status    = st;
        return row;
    endfunction

    // query word; rank mostly valid, sometimes the top rank, sometimes anything
    task automatic send_query();
        kth_pkg::cmd_word_t w;
        kth_pkg::res_word_t none_res;
        int unsigned        total;
        int                 r;
        none_res = '0;
        total    = seen_first + seen_second;
        r        = $urandom_range(0, 99);
        w.action = kth_pkg::ACT_QUERY;
        w.value  = $urandom;
        if (total > 0 && r < 80)
            w.rank = 8'($urandom_range(1, total));
        else if (total > 0 && r < 88)
            w.rank = 8'(total);
        else
            w.rank = 8'($urandom_range(0, 255));
        send_word(w, 1'b0, none_res);
    endtask

    function automatic int fill_size(bit force_full);
        int r;
        if (force_full)
            return DEPTH;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 8);
        if (r < 92)
            return $urandom_range(9, 40);
        return DEPTH;
    endfunction

    // n values in nondecreasing order, or in arrival order for a noisy set
    task automatic make_values(input int n, input int vmode, input bit noisy,
                               output logic [31:0] q[$]);
        logic [31:0] v;
        int          pos;
        q = {};
        for (int i = 0; i < n; i++)
        begin
            case (vmode)
                0: v = $urandom;
                // narrow range, lots of duplicates
                1: v = $urandom_range(0, 15) - 8;
                default:
                begin
                    case ($urandom_range(0, 4))
                        0:       v = 32'h8000_0000;
                        1:       v = 32'h7fff_ffff;
                        2:       v = 32'hffff_ffff;
                        3:       v = 32'h0000_0000;
                        default: v = 32'h0000_0001;
                    endcase
                end
            endcase
            if (noisy)
                q.push_back(v);
            else
            begin
                pos = 0;
                while (pos < q.size() && $signed(q[pos]) <= $signed(v))
                    pos++;
                q.insert(pos, v);
            end
        end
    endtask

    // random phase: maybe clear, interleaved fill, maybe overfill, queries, maybe noise
    task automatic run_sequence(input bit force_full);
        kth_pkg::cmd_word_t w;
        kth_pkg::res_word_t none_res;
        logic [31:0]        va[$];
        logic [31:0]        vb[$];
        int                 na;
        int                 nb;
        int                 ia;
        int                 ib;
        int                 vmode;
        bit                 noisy;
        bit                 to_second;
        none_res     = '0;
        src_idle_on  = ($urandom_range(0, 3) != 0);
        sink_idle_on = ($urandom_range(0, 3) != 0);
        if (force_full || $urandom_range(0, 99) < 85)
        begin
            w.action = kth_pkg::ACT_CLEAR;
            w.value  = $urandom;
            w.rank   = 8'($urandom_range(0, 255));
            send_word(w, 1'b0, none_res);
        end
        na    = fill_size(force_full);
        nb    = fill_size(force_full);
        noisy = !force_full && ($urandom_range(0, 9) == 0);
        vmode = $urandom_range(0, 2);
        make_values(na, vmode, noisy, va);
        make_values(nb, vmode, noisy, vb);
        ia = 0;
        ib = 0;
        while (ia < na || ib < nb)
        begin
            if (ia >= na)
                to_second = 1'b1;
            else if (ib >= nb)
                to_second = 1'b0;
            else
                to_second = 1'($urandom_range(0, 1));
            w.rank = 8'($urandom_range(0, 255));
            if (to_second)
            begin
                w.action = kth_pkg::ACT_APPEND_SECOND;
                w.value  = vb[ib];
                ib++;
            end
            else
            begin
                w.action = kth_pkg::ACT_APPEND_FIRST;
                w.value  = va[ia];
                ia++;
            end
            send_word(w, 1'b0, none_res);
            // the odd query while the stores are still filling
            if ($urandom_range(0, 19) == 0)
                send_query();
        end
        // push past a full store now and then
        if (force_full || $urandom_range(0, 1) == 1)
        begin
            repeat ($urandom_range(1, 3))
            begin
                w.value = $urandom;
                w.rank  = 8'($urandom_range(0, 255));
                if (seen_first == DEPTH)
                begin
                    w.action = kth_pkg::ACT_APPEND_FIRST;
                    send_word(w, 1'b0, none_res);
                end
                if (seen_second == DEPTH)
                begin
                    w.action = kth_pkg::ACT_APPEND_SECOND;
                    send_word(w, 1'b0, none_res);
                end
            end
        end
        repeat ($urandom_range(2, 8))
            send_query();
        // a little noise between phases
        if ($urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                w.action = kth_pkg::action_t'($urandom_range(0, 3));
                w.value  = $urandom;
                w.rank   = 8'($urandom_range(0, 255));
                send_word(w, 1'b0, none_res);
            end
        end
    endtask

    initial
    begin
        int seq_no;
        rst_n          = 1'b0;
        cmd_valid      = 1'b0;
        cmd            = '0;
        res_ready      = 1'b0;
        typed_row      = 1'b0;
        typed_res      = '0;
        src_idle_on    = 1'b0;
        sink_idle_on   = 1'b0;
        sink_hold      = 0;
        first_cnt      = 0;
        second_cnt     = 0;
        seen_first     = 0;
        seen_second    = 0;
        items_sent     = 0;
        mismatch_count = 0;
        words_checked  = 0;
        n_queries      = 0;
        n_ok           = 0;
        n_rank_err     = 0;
        n_full         = 0;
        n_clears       = 0;
        max_first      = 0;
        max_second     = 0;

        // directed table: fields at their extremes, every action, the rank error cases,
        // an empty first store and an unsorted store; typed rows are read off by eye
        dir_tab.push_back(mk(kth_pkg::ACT_QUERY, 32'h0000_0000, 1, 1, 0, kth_pkg::STATUS_RANK_ERR));
        dir_tab.push_back(mk(kth_pkg::ACT_APPEND_FIRST, 32'h8000_0000, 0, 0, 0, kth_pkg::STATUS_OK));
        dir_tab.push_back(mk(kth_pkg::ACT_QUERY, 32'h0000_0000, 0, 1, 0, kth_pkg::STATUS_RANK_ERR));
        dir_tab.push_back(mk(kth_pkg::ACT_APPEND_FIRST, 32'hffff_ffff, 0, 0, 0, kth_pkg::STATUS_OK));
        dir_tab.push_back(mk(kth_pkg::ACT_APPEND_FIRST, 32'h7fff_ffff, 255, 0, 0,
                             kth_pkg::STATUS_OK));
        dir_tab.push_back(mk(kth_pkg::ACT_APPEND_SECOND, 32'h0000_0000, 0, 0, 0, kth_pkg::STATUS_OK));
        dir_tab.push_back(mk(kth_pkg::ACT_APPEND_SECOND, 32'h0000_0000, 0, 0, 0, kth_pkg::STATUS_OK));
        dir_tab.push_back(mk(kth_pkg::ACT_QUERY, 32'h0000_0000, 1, 1,
                             32'h8000_0000, kth_pkg::STATUS_OK));
        dir_tab.push_back(mk(kth_pkg::ACT_QUERY, 32'hffff_ffff, 5, 1,
                             32'h7fff_ffff, kth_pkg::STATUS_OK));
        dir_tab.push_back(mk(kth_pkg::ACT_QUERY, 32'h0000_0000, 3, 0, 0, kth_pkg::STATUS_OK));
        dir_tab.push_back(mk(kth_pkg::ACT_QUERY, 32'h0000_0000, 4, 0, 0, kth_pkg::STATUS_OK));
        dir_tab.push_back(mk(kth_pkg::ACT_QUERY, 32'h0000_0000, 6, 1, 0, kth_pkg::STATUS_RANK_ERR));
        dir_tab.push_back(mk(kth_pkg::ACT_QUERY, 32'hffff_ffff, 255, 1, 0,
                             kth_pkg::STATUS_RANK_ERR));
        dir_tab.push_back(mk(kth_pkg::ACT_CLEAR, 32'h7fff_ffff, 255, 0, 0, kth_pkg::STATUS_OK));
        dir_tab.push_back(mk(kth_pkg::ACT_QUERY, 32'h0000_0000, 1, 1, 0, kth_pkg::STATUS_RANK_ERR));
        dir_tab.push_back(mk(kth_pkg::ACT_APPEND_SECOND, 32'h0000_0005, 0, 0, 0, kth_pkg::STATUS_OK));
        dir_tab.push_back(mk(kth_pkg::ACT_APPEND_SECOND, 32'h0000_0009, 0, 0, 0, kth_pkg::STATUS_OK));
        dir_tab.push_back(mk(kth_pkg::ACT_QUERY, 32'h0000_0000, 2, 0, 0, kth_pkg::STATUS_OK));
        dir_tab.push_back(mk(kth_pkg::ACT_APPEND_FIRST, 32'h0000_0064, 0, 0, 0, kth_pkg::STATUS_OK));
        dir_tab.push_back(mk(kth_pkg::ACT_APPEND_FIRST, 32'hffff_ff9c, 0, 0, 0, kth_pkg::STATUS_OK));
        dir_tab.push_back(mk(kth_pkg::ACT_APPEND_FIRST, 32'h0000_0003, 0, 0, 0, kth_pkg::STATUS_OK));
        dir_tab.push_back(mk(kth_pkg::ACT_QUERY, 32'h0000_0000, 2, 0, 0, kth_pkg::STATUS_OK));
        dir_tab.push_back(mk(kth_pkg::ACT_QUERY, 32'h0000_0000, 4, 0, 0, kth_pkg::STATUS_OK));
        dir_tab.push_back(mk(kth_pkg::ACT_CLEAR, 32'h0000_0000, 0, 0, 0, kth_pkg::STATUS_OK));

        // reset once, released on a falling edge
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_tab[i])
            send_word(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].r);
        wait_for_results();

        // first random phase fills both stores to the top and pushes past it
        seq_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            run_sequence(seq_no == 0);
            seq_no++;
            if (seq_no % 10 == 0)
                wait_for_results();
        end
        wait_for_results();

        $display("covered %0d command words in %0d phases, %0d result words checked",
                 items_sent, seq_no, words_checked);
        $display("%0d queries (%0d answered, %0d bad rank), %0d full-store words, %0d clears",
                 n_queries, n_ok, n_rank_err, n_full, n_clears);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
